FILE: rtl/tmlw_pkg.sv
// ----------------------------------------------------------------------------
// tmlw_pkg: texture mip layout walker package
// Format table, status and register codes, sequencer types.
// ----------------------------------------------------------------------------
package tmlw_pkg;

  localparam int FORMAT_TABLE_SIZE = 68;
  localparam int ROM_ENTRIES       = 68;

  localparam int FMT_W    = 7;
  localparam int DIM_W    = 16;
  localparam int MIPS_W   = 5;
  localparam int SLICES_W = 13;
  localparam int START_W  = 20;
  localparam int OFS_W    = 48;
  localparam int ROW_W    = 20;
  localparam int PITCH_W  = 36;
  localparam int SIZE_W   = 52;
  localparam int SLICE_W  = 12;
  localparam int MIP_W    = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_FMT  = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_PAST_END = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT      = 4'd0,
    REG_BASE_WIDTH  = 4'd1,
    REG_BASE_HEIGHT = 4'd2,
    REG_BASE_DEPTH  = 4'd3,
    REG_MIP_COUNT   = 4'd4,
    REG_SLICE_COUNT = 4'd5,
    REG_START       = 4'd6,
    REG_TOTAL       = 4'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_PITCH,
    S_SIZE,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    OP_ROW,
    OP_PITCH,
    OP_SIZE
  } mul_op_e;

  typedef struct packed {
    logic    idle;
    logic    mul_en;
    mul_op_e op;
    logic    grab_row;
    logic    grab_pitch;
    logic    judge;
    logic    emit;
  } ctrl_t;

  // blk: 4x4 block format; unit_bytes: bytes per block or per pixel
  typedef struct packed {
    logic       blk;
    logic [4:0] unit_bytes;
  } fmt_info_t;

  function automatic fmt_info_t fmt_lookup(input logic [FMT_W-1:0] idx);
    fmt_info_t r;
    r = '{blk: 1'b0, unit_bytes: 5'd0};
    if (idx >= 7'd1 && idx <= 7'd4) begin
      r.unit_bytes = 5'd1;
    end else if (idx >= 7'd5 && idx <= 7'd16) begin
      r.unit_bytes = 5'd2;
    end else if (idx >= 7'd17 && idx <= 7'd35) begin
      r.unit_bytes = 5'd4;
    end else if (idx >= 7'd36 && idx <= 7'd43) begin
      r.unit_bytes = 5'd8;
    end else if (idx >= 7'd44 && idx <= 7'd46) begin
      r.unit_bytes = 5'd12;
    end else if (idx >= 7'd47 && idx <= 7'd49) begin
      r.unit_bytes = 5'd16;
    end else if (idx == 7'd50 || idx == 7'd51) begin
      r.unit_bytes = 5'd4;
    end else if (idx == 7'd52 || idx == 7'd53) begin
      r.unit_bytes = 5'd8;
    end else if (idx == 7'd54 || idx == 7'd55 || idx == 7'd60 || idx == 7'd61) begin
      r = '{blk: 1'b1, unit_bytes: 5'd8};
    end else if (idx >= 7'd56 && idx <= 7'd67) begin
      r = '{blk: 1'b1, unit_bytes: 5'd16};
    end
    return r;
  endfunction

endpackage

FILE: rtl/tmlw_mul.sv
// ----------------------------------------------------------------------------
// tmlw_mul: shared multiplier
// One multiply per enabled cycle, product registered.
// ----------------------------------------------------------------------------
module tmlw_mul (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [tmlw_pkg::PITCH_W-1:0]      a_i,
  input  logic [tmlw_pkg::DIM_W-1:0]        b_i,
  output logic [tmlw_pkg::SIZE_W-1:0]       p_o
);

  logic [tmlw_pkg::SIZE_W-1:0] p_q, p_d;

  always_comb begin
    p_d = p_q;
    if (en_i) begin
      p_d = tmlw_pkg::SIZE_W'(a_i) * tmlw_pkg::SIZE_W'(b_i);
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/tmlw_ctrl.sv
// ----------------------------------------------------------------------------
// tmlw_ctrl: walker sequencer
// Runs row, pitch and size passes (row only on early error), then emits.
// ----------------------------------------------------------------------------
module tmlw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            early_err_i,
  input  logic            out_free_i,
  output tmlw_pkg::ctrl_t ctrl_o
);

  tmlw_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmlw_pkg::S_IDLE: begin
        if (in_valid_i) state_d = tmlw_pkg::S_ROW;
      end
      tmlw_pkg::S_ROW: begin
        state_d = early_err_i ? tmlw_pkg::S_EMIT : tmlw_pkg::S_PITCH;
      end
      tmlw_pkg::S_PITCH: state_d = tmlw_pkg::S_SIZE;
      tmlw_pkg::S_SIZE:  state_d = tmlw_pkg::S_EMIT;
      tmlw_pkg::S_EMIT: begin
        if (out_free_i) state_d = tmlw_pkg::S_IDLE;
      end
      default: state_d = tmlw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '{idle: 1'b0, mul_en: 1'b0, op: tmlw_pkg::OP_ROW, grab_row: 1'b0,
               grab_pitch: 1'b0, judge: 1'b0, emit: 1'b0};
    unique case (state_q)
      tmlw_pkg::S_IDLE: ctrl_o.idle = 1'b1;
      tmlw_pkg::S_ROW: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op     = tmlw_pkg::OP_ROW;
        ctrl_o.judge  = 1'b1;
      end
      tmlw_pkg::S_PITCH: begin
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.op       = tmlw_pkg::OP_PITCH;
        ctrl_o.grab_row = 1'b1;
      end
      tmlw_pkg::S_SIZE: begin
        ctrl_o.mul_en     = 1'b1;
        ctrl_o.op         = tmlw_pkg::OP_SIZE;
        ctrl_o.grab_pitch = 1'b1;
      end
      tmlw_pkg::S_EMIT: ctrl_o.emit = out_free_i;
      default: ctrl_o.idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmlw_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/texture_mip_layout_walker.sv
// ----------------------------------------------------------------------------
// texture_mip_layout_walker: texture subresource layout walker
// Walks slices (outer) and mips (inner), one subresource layout per request.
// ----------------------------------------------------------------------------
// Passes: a normal subresource makes three passes through the one shared
//   multiplier for row, pitch and size, then the offset add and range
//   compare; a request answered with a stored error, past end or bad
//   format goes from the row pass straight to the result word.
// Requests: a new request is taken only once the sequencer is back in
//   idle, after its result word has been loaded into a free output register.
// Reset: sequencer idle, walk marked done, so requests answer past end until
//   a restart; registers take their documented reset values.
module texture_mip_layout_walker #(
  parameter int FormatTableSize = tmlw_pkg::FORMAT_TABLE_SIZE
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tmlw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tmlw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tmlw_pkg::SLICE_W-1:0]        slice_index_o,
  output logic [tmlw_pkg::MIP_W-1:0]          mip_index_o,
  output logic [tmlw_pkg::OFS_W-1:0]          byte_offset_o,
  output logic [tmlw_pkg::ROW_W-1:0]          row_pitch_o,
  output logic [tmlw_pkg::PITCH_W-1:0]        slice_pitch_o,
  output logic [tmlw_pkg::SIZE_W-1:0]         level_size_o,
  output logic [1:0]                          status_o,
  output logic                                last_of_walk_o
);

  localparam int DimW = tmlw_pkg::DIM_W;
  localparam int OfsW = tmlw_pkg::OFS_W;

  // configuration registers
  logic [tmlw_pkg::FMT_W-1:0]    cfg_fmt_q;
  logic [DimW-1:0]               cfg_w_q, cfg_h_q, cfg_d_q;
  logic [tmlw_pkg::MIPS_W-1:0]   cfg_mips_q;
  logic [tmlw_pkg::SLICES_W-1:0] cfg_slices_q;
  logic [tmlw_pkg::START_W-1:0]  cfg_start_q;
  logic [OfsW-1:0]               cfg_total_q;

  // walk state
  logic [tmlw_pkg::SLICE_W-1:0]  slice_q;
  logic [tmlw_pkg::MIP_W-1:0]    mip_q;
  logic [DimW-1:0]               cur_w_q, cur_h_q, cur_d_q;
  logic [OfsW-1:0]               ofs_q;
  logic                          done_q;
  tmlw_pkg::status_e             sticky_q;
  tmlw_pkg::status_e             stat_q;

  logic [tmlw_pkg::ROW_W-1:0]    row_q;
  logic [tmlw_pkg::PITCH_W-1:0]  pitch_q;

  // output register
  logic                          out_valid_q;
  logic [tmlw_pkg::SLICE_W-1:0]  o_slice_q;
  logic [tmlw_pkg::MIP_W-1:0]    o_mip_q;
  logic [OfsW-1:0]               o_ofs_q;
  logic [tmlw_pkg::ROW_W-1:0]    o_row_q;
  logic [tmlw_pkg::PITCH_W-1:0]  o_pitch_q;
  logic [tmlw_pkg::SIZE_W-1:0]   o_size_q;
  tmlw_pkg::status_e             o_stat_q;
  logic                          o_last_q;

  tmlw_pkg::ctrl_t               ctrl;
  tmlw_pkg::fmt_info_t           fmt;
  tmlw_pkg::status_e             pre_stat;
  logic                          fmt_bad;
  logic                          early_err;
  logic                          out_free;
  logic                          in_take;
  logic [tmlw_pkg::PITCH_W-1:0]  mul_a;
  logic [DimW-1:0]               mul_b;
  logic [tmlw_pkg::SIZE_W-1:0]   mul_p;
  logic [DimW:0]                 w_plus3, h_plus3;
  logic [tmlw_pkg::SIZE_W:0]     end_sum;
  logic                          range_err;
  logic [tmlw_pkg::MIPS_W-1:0]   mips_eff;
  logic [tmlw_pkg::SLICES_W-1:0] slices_eff;
  logic                          last_mip, last_slice;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ctrl.idle;
  assign in_take     = in_valid_i && ctrl.idle;
  assign out_free    = !out_valid_q || out_ready_i;

  assign fmt     = tmlw_pkg::fmt_lookup(cfg_fmt_q);
  assign fmt_bad = (cfg_fmt_q == '0) ||
                   ({1'b0, cfg_fmt_q} >= 8'(FormatTableSize)) ||
                   ({1'b0, cfg_fmt_q} >= 8'(tmlw_pkg::ROM_ENTRIES));

  always_comb begin
    priority if (sticky_q != tmlw_pkg::STAT_OK) begin
      pre_stat = sticky_q;
    end else if (done_q) begin
      pre_stat = tmlw_pkg::STAT_PAST_END;
    end else if (fmt_bad) begin
      pre_stat = tmlw_pkg::STAT_BAD_FMT;
    end else begin
      pre_stat = tmlw_pkg::STAT_OK;
    end
  end
  assign early_err = (pre_stat != tmlw_pkg::STAT_OK);

  // operand selection for the shared multiplier
  assign w_plus3 = {1'b0, cur_w_q} + (DimW+1)'(3);
  assign h_plus3 = {1'b0, cur_h_q} + (DimW+1)'(3);

  always_comb begin
    unique case (ctrl.op)
      tmlw_pkg::OP_ROW: begin
        mul_a = fmt.blk ? tmlw_pkg::PITCH_W'(w_plus3[DimW:2])
                        : tmlw_pkg::PITCH_W'(cur_w_q);
        mul_b = DimW'(fmt.unit_bytes);
      end
      tmlw_pkg::OP_PITCH: begin
        mul_a = tmlw_pkg::PITCH_W'(mul_p[tmlw_pkg::ROW_W-1:0]);
        mul_b = fmt.blk ? DimW'(h_plus3[DimW:2]) : cur_h_q;
      end
      tmlw_pkg::OP_SIZE: begin
        mul_a = mul_p[tmlw_pkg::PITCH_W-1:0];
        mul_b = cur_d_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tmlw_mul u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  tmlw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .early_err_i (early_err),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl)
  );

  // end of subresource against data length
  assign end_sum   = (tmlw_pkg::SIZE_W+1)'(ofs_q) + (tmlw_pkg::SIZE_W+1)'(mul_p);
  assign range_err = end_sum > (tmlw_pkg::SIZE_W+1)'(cfg_total_q);

  always_comb begin
    if (cfg_mips_q == '0) begin
      mips_eff = tmlw_pkg::MIPS_W'(1);
    end else if (cfg_mips_q > tmlw_pkg::MIPS_W'(16)) begin
      mips_eff = tmlw_pkg::MIPS_W'(16);
    end else begin
      mips_eff = cfg_mips_q;
    end
    if (cfg_slices_q == '0) begin
      slices_eff = tmlw_pkg::SLICES_W'(1);
    end else if (cfg_slices_q > tmlw_pkg::SLICES_W'(4096)) begin
      slices_eff = tmlw_pkg::SLICES_W'(4096);
    end else begin
      slices_eff = cfg_slices_q;
    end
  end

  assign last_mip   = ({1'b0, mip_q} + tmlw_pkg::MIPS_W'(1)) >= mips_eff;
  assign last_slice = ({1'b0, slice_q} + tmlw_pkg::SLICES_W'(1)) >= slices_eff;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_fmt_q    <= '0;
      cfg_w_q      <= DimW'(1);
      cfg_h_q      <= DimW'(1);
      cfg_d_q      <= DimW'(1);
      cfg_mips_q   <= tmlw_pkg::MIPS_W'(1);
      cfg_slices_q <= tmlw_pkg::SLICES_W'(1);
      cfg_start_q  <= tmlw_pkg::START_W'(128);
      cfg_total_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tmlw_pkg::REG_FORMAT:      cfg_fmt_q    <= cfg_data_i[tmlw_pkg::FMT_W-1:0];
        tmlw_pkg::REG_BASE_WIDTH:  cfg_w_q      <= cfg_data_i[DimW-1:0];
        tmlw_pkg::REG_BASE_HEIGHT: cfg_h_q      <= cfg_data_i[DimW-1:0];
        tmlw_pkg::REG_BASE_DEPTH:  cfg_d_q      <= cfg_data_i[DimW-1:0];
        tmlw_pkg::REG_MIP_COUNT:   cfg_mips_q   <= cfg_data_i[tmlw_pkg::MIPS_W-1:0];
        tmlw_pkg::REG_SLICE_COUNT: cfg_slices_q <= cfg_data_i[tmlw_pkg::SLICES_W-1:0];
        tmlw_pkg::REG_START:       cfg_start_q  <= cfg_data_i[tmlw_pkg::START_W-1:0];
        tmlw_pkg::REG_TOTAL:       cfg_total_q  <= cfg_data_i[OfsW-1:0];
        default: ;
      endcase
    end
  end

  // walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q  <= '0;
      mip_q    <= '0;
      cur_w_q  <= DimW'(1);
      cur_h_q  <= DimW'(1);
      cur_d_q  <= DimW'(1);
      ofs_q    <= '0;
      done_q   <= 1'b1;
      sticky_q <= tmlw_pkg::STAT_OK;
      stat_q   <= tmlw_pkg::STAT_OK;
    end else begin
      if (in_take && restart_i) begin
        slice_q  <= '0;
        mip_q    <= '0;
        cur_w_q  <= cfg_w_q;
        cur_h_q  <= cfg_h_q;
        cur_d_q  <= cfg_d_q;
        ofs_q    <= OfsW'(cfg_start_q);
        done_q   <= 1'b0;
        sticky_q <= tmlw_pkg::STAT_OK;
      end
      if (ctrl.judge) begin
        stat_q <= pre_stat;
        if (pre_stat == tmlw_pkg::STAT_BAD_FMT) sticky_q <= tmlw_pkg::STAT_BAD_FMT;
      end
      if (ctrl.emit && stat_q == tmlw_pkg::STAT_OK) begin
        if (range_err) begin
          sticky_q <= tmlw_pkg::STAT_RANGE;
        end else begin
          ofs_q <= end_sum[OfsW-1:0];
          if (last_mip) begin
            if (last_slice) begin
              done_q <= 1'b1;
            end else begin
              slice_q <= slice_q + tmlw_pkg::SLICE_W'(1);
              mip_q   <= '0;
              cur_w_q <= cfg_w_q;
              cur_h_q <= cfg_h_q;
              cur_d_q <= cfg_d_q;
            end
          end else begin
            // halve each dimension, floor of one
            mip_q   <= mip_q + tmlw_pkg::MIP_W'(1);
            cur_w_q <= (cur_w_q > DimW'(1)) ? (cur_w_q >> 1) : DimW'(1);
            cur_h_q <= (cur_h_q > DimW'(1)) ? (cur_h_q >> 1) : DimW'(1);
            cur_d_q <= (cur_d_q > DimW'(1)) ? (cur_d_q >> 1) : DimW'(1);
          end
        end
      end
    end
  end

  // hold row and pitch as the multiplier moves on
  always_ff @(posedge clk_i) begin
    if (ctrl.grab_row)   row_q   <= mul_p[tmlw_pkg::ROW_W-1:0];
    if (ctrl.grab_pitch) pitch_q <= mul_p[tmlw_pkg::PITCH_W-1:0];
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      if (stat_q != tmlw_pkg::STAT_OK || range_err) begin
        o_slice_q <= '0;
        o_mip_q   <= '0;
        o_ofs_q   <= '0;
        o_row_q   <= '0;
        o_pitch_q <= '0;
        o_size_q  <= '0;
        o_last_q  <= 1'b0;
        o_stat_q  <= (stat_q != tmlw_pkg::STAT_OK) ? stat_q : tmlw_pkg::STAT_RANGE;
      end else begin
        o_slice_q <= slice_q;
        o_mip_q   <= mip_q;
        o_ofs_q   <= ofs_q;
        o_row_q   <= row_q;
        o_pitch_q <= pitch_q;
        o_size_q  <= mul_p;
        o_last_q  <= last_mip && last_slice;
        o_stat_q  <= tmlw_pkg::STAT_OK;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slice_index_o  = o_slice_q;
  assign mip_index_o    = o_mip_q;
  assign byte_offset_o  = o_ofs_q;
  assign row_pitch_o    = o_row_q;
  assign slice_pitch_o  = o_pitch_q;
  assign level_size_o   = o_size_q;
  assign status_o       = o_stat_q;
  assign last_of_walk_o = o_last_q;

  // an accepted request keeps the sequencer busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while sequencer busy");

  // an error word carries no layout
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != tmlw_pkg::STAT_OK |->
      level_size_o == '0 && byte_offset_o == '0 && last_of_walk_o == 1'b0)
    else $error("error word with non-zero fields");

  // a new word is only loaded once the previous one has left
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !ctrl.emit)
    else $error("result word overwritten before taken");

endmodule
